// ===== hw/rtl/sete_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander package
// Field widths, register indexes and the decoded entry record shared by the
// channel interfaces and the expander.
// ----------------------------------------------------------------------------
package sete_pkg;

	// Entry word and command field widths.
	localparam int WORD_W   = 16;
	localparam int CODE_W   = 11;
	localparam int SX_W     = 10;
	localparam int SY_W     = 9;
	localparam int COLOR_W  = 11;
	localparam int PAL_W    = 10;
	localparam int POS_W    = 9;
	localparam int STACK_W  = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = PAL_W;

	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_PASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_BASE  = 2'd1;

	localparam logic [PAL_W-1:0] PALETTE_BASE_RST = 10'd512;

	// Horizontal decode: codes from the wrap point up map to negative x, and
	// those below the left clip limit are off screen.
	localparam logic [POS_W-1:0] X_WRAP   = 9'd320;
	localparam logic [POS_W-1:0] X_CLIP   = 9'd496;
	localparam logic [POS_W-1:0] Y_OFFSET = 9'd16;

	// Bit positions inside the entry words.
	localparam int BIT_FLICKER  = 12;
	localparam int BIT_FLIP_X   = 13;
	localparam int BIT_FLIP_Y   = 14;
	localparam int BIT_PRIORITY = 13;
	localparam int HEIGHT_LO    = 9;
	localparam int COLOR_LO     = 9;

	// One kept entry, decoded and waiting to be expanded.
	typedef struct packed {
		logic [CODE_W-1:0]  base;
		logic [STACK_W-1:0] span;
		logic [SX_W-1:0]    sx;
		logic [SY_W-1:0]    sy;
		logic               flip_x;
		logic               flip_y;
		logic [COLOR_W-1:0] color;
	} entry_t;

endpackage

// ===== hw/rtl/sete_entry_if.sv =====
// ----------------------------------------------------------------------------
// Sprite entry channel
// One beat carries a three-word sprite list entry and the frame parity.
// ----------------------------------------------------------------------------
interface sete_entry_if;
	import sete_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_position_y;
	logic [WORD_W-1:0] word_tile;
	logic [WORD_W-1:0] word_position_x;
	logic              odd_frame;

	modport source (
		output valid, word_position_y, word_tile, word_position_x, odd_frame,
		input  ready
	);

	modport sink (
		input  valid, word_position_y, word_tile, word_position_x, odd_frame,
		output ready
	);

endinterface

// ===== hw/rtl/sete_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Tile command channel
// One beat carries one 16x16 tile draw command.
// ----------------------------------------------------------------------------
interface sete_cmd_if;
	import sete_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CODE_W-1:0]        tile_code;
	logic signed [SX_W-1:0]   screen_x;
	logic signed [SY_W-1:0]   screen_y;
	logic                     mirror_x;
	logic                     mirror_y;
	logic [COLOR_W-1:0]       color_index;
	logic                     last_tile;

	modport source (
		output valid, tile_code, screen_x, screen_y, mirror_x, mirror_y,
		       color_index, last_tile,
		input  ready
	);

	modport sink (
		input  valid, tile_code, screen_x, screen_y, mirror_x, mirror_y,
		       color_index, last_tile,
		output ready
	);

endinterface

// ===== hw/rtl/sprite_entry_tile_expander.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander
// Decodes sprite list entries and expands each kept one into a column of
// tile draw commands.
// ----------------------------------------------------------------------------
// An entry beat is decoded as it is taken: it is dropped at once when its
// priority bit differs from the configured pass, when it is a flicker sprite
// on an odd frame, or when its wrapped x lies off screen. A kept entry lands
// in the stage register and a down counter then issues its 1, 2, 4 or 8 tile
// commands, top tile first, one per cycle into the output register while the
// output is not stalled. The stage takes the next entry in the cycle its last
// tile moves on, so a kept entry holds off further entries until all of its
// tiles have moved on, while a dropped entry never enters the stage.
// Configuration writes take effect on the next entry taken.
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander (
	input  logic                          clk,
	input  logic                          arst_n,
	sete_entry_if.sink                    entry,
	sete_cmd_if.source                    cmd,
	input  logic                          cfg_wr_en,
	input  logic [sete_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sete_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sete_pkg::*;

	logic               priority_pass_q;
	logic [PAL_W-1:0]   palette_base_q;

	logic               valid_s1;
	entry_t             entry_s1;
	logic [STACK_W-1:0] k_q;

	logic               out_valid_q;

	logic [POS_W-1:0]   x9;
	logic               x_wrap;
	logic               keep;
	entry_t             decoded;
	logic               out_free;
	logic               emit;
	logic               last_emit;
	logic               load;
	logic [CODE_W-1:0]  k_ext;
	logic [CODE_W-1:0]  code_next;
	logic [SY_W-1:0]    sy_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priority_pass_q <= 1'b0;
			palette_base_q  <= PALETTE_BASE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PRIORITY_PASS: priority_pass_q <= cfg_wdata[0];
				REG_PALETTE_BASE:  palette_base_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Entry decode and drop decision.
	always_comb begin
		x9     = entry.word_position_x[POS_W-1:0];
		x_wrap = (x9 >= X_WRAP);
		keep   = (entry.word_position_x[BIT_PRIORITY] == priority_pass_q)
		      && !(entry.word_position_y[BIT_FLICKER] && entry.odd_frame)
		      && !(x_wrap && (x9 < X_CLIP));

		decoded.span   = STACK_W'((4'd1 << entry.word_position_y[HEIGHT_LO +: 2]) - 4'd1);
		decoded.base   = entry.word_tile[CODE_W-1:0] & ~{{(CODE_W-STACK_W){1'b0}}, decoded.span};
		decoded.sx     = {x_wrap, x9};
		decoded.sy     = entry.word_position_y[POS_W-1:0] - Y_OFFSET;
		decoded.flip_x = entry.word_position_y[BIT_FLIP_X];
		decoded.flip_y = entry.word_position_y[BIT_FLIP_Y];
		decoded.color  = {1'b0, palette_base_q}
		               + {3'b000, entry.word_position_x[COLOR_LO +: 4], 4'b0000};
	end

	// Handshake: the stage frees up when its last tile moves to the output.
	assign out_free    = !out_valid_q || cmd.ready;
	assign emit        = valid_s1 && out_free;
	assign last_emit   = emit && (k_q == '0);
	assign entry.ready = !valid_s1 || last_emit;
	assign load        = entry.valid && entry.ready && keep;

	// Stage register and tile counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_q      <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			k_q      <= decoded.span;
		end else if (last_emit) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			k_q <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_s1 <= decoded;
		end
	end

	// Per-tile code and vertical position.
	always_comb begin
		k_ext   = {{(CODE_W-STACK_W){1'b0}}, k_q};
		sy_next = entry_s1.sy - {2'b00, k_q, 4'b0000};
		if (entry_s1.flip_y) begin
			code_next = entry_s1.base - k_ext;
		end else begin
			code_next = entry_s1.base + {{(CODE_W-STACK_W){1'b0}}, entry_s1.span} + k_ext;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cmd.tile_code   <= code_next;
			cmd.screen_x    <= $signed(entry_s1.sx);
			cmd.screen_y    <= $signed(sy_next);
			cmd.mirror_x    <= entry_s1.flip_x;
			cmd.mirror_y    <= entry_s1.flip_y;
			cmd.color_index <= entry_s1.color;
			cmd.last_tile   <= (k_q == '0);
		end
	end

	assign cmd.valid = out_valid_q;

	// The counter never runs above the span of the entry it expands.
	a_k_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (k_q <= entry_s1.span))
		else $error("tile counter above entry span");

	// A tile that is not the last one keeps the stage busy with one fewer left.
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (k_q != '0)) |=> (valid_s1 && (k_q == $past(k_q) - 1'b1)))
		else $error("tile counter did not step down");

	// Each issued tile shows up on the output with the matching last mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (cmd.valid && (cmd.last_tile == ($past(k_q) == '0))))
		else $error("last tile mark does not follow the counter");

	// A new entry is taken only once the previous one has issued its last tile.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_emit) |-> !load)
		else $error("entry loaded over a busy stage");

endmodule

// ===== sim/tb_sprite_entry_tile_expander.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite entry tile expander testbench
// Drives sprite list entries and register writes into the expander, predicts
// the tile commands of every accepted entry beat and checks each command beat
// against the oldest prediction. It covers a directed set of edge cases,
// random entries under several idle and stall patterns, and a long output
// hold-off that fills the block.
// ----------------------------------------------------------------------------

import sete_pkg::*;

// One predicted or observed tile command.
typedef struct packed {
	logic [CODE_W-1:0]         tile_code;
	logic signed [SX_W-1:0]    screen_x;
	logic signed [SY_W-1:0]    screen_y;
	logic                      mirror_x;
	logic                      mirror_y;
	logic [COLOR_W-1:0]        color_index;
	logic                      last_tile;
} tile_cmd_t;

// Predicts the tile column of each entry and checks the command stream.
class tile_cmd_scoreboard;
	localparam int REPORT_LIMIT = 10;
	localparam int SCREEN_W     = 320;
	localparam int POS_SPAN     = 512;
	localparam int CLIP_LEFT    = -16;
	localparam int TILE_H       = 16;

	bit               pass_sel = 1'b0;
	logic [PAL_W-1:0] palette  = PALETTE_BASE_RST;
	tile_cmd_t        expected_tiles[$];
	int               failures = 0;

	function void set_pass(bit value);
		pass_sel = value;
	endfunction

	function void set_palette(logic [PAL_W-1:0] value);
		palette = value;
	endfunction

	function int pending();
		return expected_tiles.size();
	endfunction

	// Works out the commands for one accepted entry beat.
	function void expand_entry(logic [WORD_W-1:0] wy, logic [WORD_W-1:0] wt,
			logic [WORD_W-1:0] wx, logic odd);
		tile_cmd_t         cmd;
		int                span;
		int                x;
		int                y;
		logic [CODE_W-1:0] base;
		if (wx[BIT_PRIORITY] != pass_sel)
			return;
		if (wy[BIT_FLICKER] && odd)
			return;
		x = int'(wx[POS_W-1:0]);
		y = int'(wy[POS_W-1:0]) - TILE_H;
		if (x >= SCREEN_W)
			x -= POS_SPAN;
		if (y >= POS_SPAN / 2)
			y -= POS_SPAN;
		if (x < CLIP_LEFT)
			return;
		span = (1 << wy[HEIGHT_LO +: 2]) - 1;
		// Codes wrap at 11 bits, so only the low bits of the tile word matter.
		base = wt[CODE_W-1:0] & ~CODE_W'(span);
		for (int k = span; k >= 0; k--) begin
			cmd.tile_code   = wy[BIT_FLIP_Y] ? base - CODE_W'(k)
			                                 : base + CODE_W'(span) + CODE_W'(k);
			cmd.screen_x    = SX_W'(x);
			cmd.screen_y    = SY_W'(y - TILE_H * k);
			cmd.mirror_x    = wy[BIT_FLIP_X];
			cmd.mirror_y    = wy[BIT_FLIP_Y];
			cmd.color_index = COLOR_W'(palette) + COLOR_W'({wx[COLOR_LO +: 4], 4'b0000});
			cmd.last_tile   = (k == 0);
			expected_tiles.push_back(cmd);
		end
	endfunction

	function void note_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $time, msg);
	endfunction

	function void compare_field(string field, logic signed [15:0] want,
			logic signed [15:0] got);
		if (want !== got)
			note_failure($sformatf("%s expected %0d, got %0d", field, want, got));
	endfunction

	// Checks one accepted command beat against the oldest prediction.
	function void check_tile(tile_cmd_t got);
		tile_cmd_t want;
		if (expected_tiles.size() == 0) begin
			note_failure($sformatf("unexpected tile command, code %0d x %0d y %0d",
				got.tile_code, got.screen_x, got.screen_y));
			return;
		end
		want = expected_tiles.pop_front();
		compare_field("tile_code", want.tile_code, got.tile_code);
		compare_field("screen_x", want.screen_x, got.screen_x);
		compare_field("screen_y", want.screen_y, got.screen_y);
		compare_field("mirror_x", want.mirror_x, got.mirror_x);
		compare_field("mirror_y", want.mirror_y, got.mirror_y);
		compare_field("color_index", want.color_index, got.color_index);
		compare_field("last_tile", want.last_tile, got.last_tile);
	endfunction
endclass

module tb_sprite_entry_tile_expander;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 20;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    hold_reqs = 0;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	int                    src_idle_pct  = 0;
	int                    snk_stall_pct = 0;
	int unsigned           cycle_count   = 0;
	tile_cmd_scoreboard    sb = new();

	sete_entry_if entry_ch();
	sete_cmd_if   cmd_ch();

	sprite_entry_tile_expander DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (entry_ch),
		.cmd       (cmd_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** sprite_entry_tile_expander: FAILED **");
			$finish;
		end
	end

	// Command receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd_ch.ready <= 1'b0;
		end else begin
			cmd_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Every accepted command beat goes to the checker.
	always @(posedge clk) begin
		tile_cmd_t got;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			got.tile_code   = cmd_ch.tile_code;
			got.screen_x    = cmd_ch.screen_x;
			got.screen_y    = cmd_ch.screen_y;
			got.mirror_x    = cmd_ch.mirror_x;
			got.mirror_y    = cmd_ch.mirror_y;
			got.color_index = cmd_ch.color_index;
			got.last_tile   = cmd_ch.last_tile;
			sb.check_tile(got);
		end
	end

	function automatic logic [WORD_W-1:0] pack_y(int y, int height, bit flicker,
			bit fx, bit fy);
		return {1'b0, fy, fx, flicker, 1'b0, 2'(height), POS_W'(y)};
	endfunction

	function automatic logic [WORD_W-1:0] pack_x(int x, int color, bit prio);
		return {2'b00, prio, 4'(color), POS_W'(x)};
	endfunction

	// Offers one entry beat after an optional idle gap; returns at the edge
	// where it is taken, with valid still high.
	task automatic send_entry(input logic [WORD_W-1:0] wy, input logic [WORD_W-1:0] wt,
			input logic [WORD_W-1:0] wx, input logic odd);
		if ($urandom_range(99) < src_idle_pct) begin
			entry_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		entry_ch.valid           <= 1'b1;
		entry_ch.word_position_y <= wy;
		entry_ch.word_tile       <= wt;
		entry_ch.word_position_x <= wx;
		entry_ch.odd_frame       <= odd;
		@(posedge clk);
		while (!entry_ch.ready)
			@(posedge clk);
		sb.expand_entry(wy, wt, wx, odd);
	endtask

	// Stops offering entries until every predicted command has arrived and
	// the block has had time to finish any dropped entry.
	task automatic pause_until_drained();
		entry_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers, then junk to a spare index that must be ignored.
	task automatic configure(input bit pass_value, input logic [PAL_W-1:0] palette_value);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PRIORITY_PASS;
		cfg_wdata <= {(CFG_DATA_W-1)'($urandom), pass_value};
		@(posedge clk);
		cfg_index <= REG_PALETTE_BASE;
		cfg_wdata <= palette_value;
		@(posedge clk);
		cfg_index <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_PALETTE_BASE + 1));
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_pass(pass_value);
		sb.set_palette(palette_value);
		@(posedge clk);
	endtask

	// Random entries, mostly drawn in this pass and on screen.
	task automatic send_random_entries(input int count);
		logic [WORD_W-1:0] wy;
		logic [WORD_W-1:0] wt;
		logic [WORD_W-1:0] wx;
		logic              odd;
		repeat (count) begin
			wy  = WORD_W'($urandom);
			wt  = WORD_W'($urandom);
			wx  = WORD_W'($urandom);
			odd = 1'($urandom);
			wy[BIT_FLICKER]  = ($urandom_range(3) == 0);
			wx[BIT_PRIORITY] = ($urandom_range(99) < 85) ? sb.pass_sel : !sb.pass_sel;
			case ($urandom_range(9))
				0, 1: ;
				2: wx[POS_W-1:0] = POS_W'(496 + $urandom_range(15));
				default: wx[POS_W-1:0] = POS_W'($urandom_range(319));
			endcase
			send_entry(wy, wt, wx, odd);
		end
	endtask

	initial begin
		entry_ch.valid           = 1'b0;
		entry_ch.word_position_y = '0;
		entry_ch.word_tile       = '0;
		entry_ch.word_position_x = '0;
		entry_ch.odd_frame       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed entries under the reset settings (pass 0, palette 512).
		send_entry(pack_y(100, 0, 0, 0, 0), 16'h0010, pack_x(50, 3, 1), 1'b0);
		send_entry(pack_y(100, 1, 1, 0, 0), 16'h0020, pack_x(50, 3, 0), 1'b1);
		send_entry(pack_y(100, 1, 1, 0, 0), 16'h0020, pack_x(50, 3, 0), 1'b0);
		send_entry(pack_y(16, 0, 0, 0, 0), 16'h0001, pack_x(0, 0, 0), 1'b1);
		send_entry(pack_y(271, 0, 0, 0, 0), 16'h0002, pack_x(319, 1, 0), 1'b0);
		send_entry(pack_y(60, 0, 0, 0, 0), 16'h0003, pack_x(320, 2, 0), 1'b0);
		send_entry(pack_y(60, 0, 0, 0, 0), 16'h0004, pack_x(495, 2, 0), 1'b0);
		send_entry(pack_y(60, 1, 0, 0, 0), 16'h0005, pack_x(496, 4, 0), 1'b0);
		send_entry(pack_y(60, 2, 0, 0, 0), 16'h0006, pack_x(511, 5, 0), 1'b0);
		send_entry(pack_y(0, 3, 0, 0, 0), 16'h3fff, pack_x(8, 6, 0), 1'b0);
		send_entry(pack_y(272, 3, 0, 0, 1), 16'h0003, pack_x(100, 7, 0), 1'b0);
		send_entry(pack_y(511, 3, 0, 1, 1), 16'h0123, pack_x(200, 15, 0), 1'b0);
		send_entry(pack_y(160, 1, 0, 0, 1), 16'h07ff, pack_x(160, 9, 0), 1'b1);
		send_entry(pack_y(90, 2, 0, 1, 0) | 16'h8800, 16'hc456,
			pack_x(33, 10, 0) | 16'hc000, 1'b1);
		send_entry(16'hffff, 16'hffff, 16'hdfff, 1'b0);
		send_entry(16'h0000, 16'h0000, 16'h0000, 1'b1);
		pause_until_drained();

		// No idling, other pass, top of the palette range.
		configure(1'b1, 10'd1023);
		send_random_entries(PHASE_ITEMS);
		pause_until_drained();

		// Sender mostly idle, palette at zero.
		configure(1'b0, 10'd0);
		src_idle_pct = 84;
		send_random_entries(PHASE_ITEMS);
		pause_until_drained();

		// Receiver mostly stalling.
		configure(1'b1, PAL_W'($urandom));
		src_idle_pct  = 0;
		snk_stall_pct = 84;
		send_random_entries(PHASE_ITEMS);
		pause_until_drained();

		// Light idling on both sides.
		configure(1'b0, PAL_W'($urandom));
		src_idle_pct  = 18;
		snk_stall_pct = 18;
		send_random_entries(PHASE_ITEMS);
		pause_until_drained();

		// Long receiver hold-off while entries keep coming, so the block backs up.
		configure(1'($urandom), PAL_W'($urandom));
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_reqs <= hold_reqs + 1;
		send_random_entries(PHASE_ITEMS + 5);
		pause_until_drained();

		if (sb.failures == 0) begin
			$display("** sprite_entry_tile_expander: PASSED **");
		end else begin
			$display("** sprite_entry_tile_expander: FAILED **");
		end
		$finish;
	end

endmodule
